// ===== hw/rtl/rv32dp_pkg.sv =====
package rv32dp_pkg;

   // Major opcodes, instruction bits 6:0
   localparam logic [6:0] OPC_LUI    = 7'd55;
   localparam logic [6:0] OPC_AUIPC  = 7'd23;
   localparam logic [6:0] OPC_JAL    = 7'd111;
   localparam logic [6:0] OPC_JALR   = 7'd103;
   localparam logic [6:0] OPC_BRANCH = 7'd99;
   localparam logic [6:0] OPC_LOAD   = 7'd3;
   localparam logic [6:0] OPC_STORE  = 7'd35;
   localparam logic [6:0] OPC_IMM    = 7'd19;
   localparam logic [6:0] OPC_REG    = 7'd51;

   // addi a0, zero, 255 doubles as the halt marker
   localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;

   // Dense operation codes
   localparam logic [5:0] OP_LUI     = 6'd0;
   localparam logic [5:0] OP_AUIPC   = 6'd1;
   localparam logic [5:0] OP_JAL     = 6'd2;
   localparam logic [5:0] OP_JALR    = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLT     = 6'd6;
   localparam logic [5:0] OP_BGE     = 6'd7;
   localparam logic [5:0] OP_BLTU    = 6'd8;
   localparam logic [5:0] OP_BGEU    = 6'd9;
   localparam logic [5:0] OP_LB      = 6'd10;
   localparam logic [5:0] OP_LH      = 6'd11;
   localparam logic [5:0] OP_LW      = 6'd12;
   localparam logic [5:0] OP_LBU     = 6'd13;
   localparam logic [5:0] OP_LHU     = 6'd14;
   localparam logic [5:0] OP_SB      = 6'd15;
   localparam logic [5:0] OP_SH      = 6'd16;
   localparam logic [5:0] OP_SW      = 6'd17;
   localparam logic [5:0] OP_ADDI    = 6'd18;
   localparam logic [5:0] OP_SLTI    = 6'd19;
   localparam logic [5:0] OP_SLTIU   = 6'd20;
   localparam logic [5:0] OP_XORI    = 6'd21;
   localparam logic [5:0] OP_ORI     = 6'd22;
   localparam logic [5:0] OP_ANDI    = 6'd23;
   localparam logic [5:0] OP_SLLI    = 6'd24;
   localparam logic [5:0] OP_SRLI    = 6'd25;
   localparam logic [5:0] OP_SRAI    = 6'd26;
   localparam logic [5:0] OP_ADD     = 6'd27;
   localparam logic [5:0] OP_SUB     = 6'd28;
   localparam logic [5:0] OP_SLL     = 6'd29;
   localparam logic [5:0] OP_SLT     = 6'd30;
   localparam logic [5:0] OP_SLTU    = 6'd31;
   localparam logic [5:0] OP_XOR     = 6'd32;
   localparam logic [5:0] OP_SRL     = 6'd33;
   localparam logic [5:0] OP_SRA     = 6'd34;
   localparam logic [5:0] OP_OR      = 6'd35;
   localparam logic [5:0] OP_AND     = 6'd36;
   localparam logic [5:0] OP_HALT    = 6'd37;
   localparam logic [5:0] OP_ILLEGAL = 6'd38;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] fetch_pc;
      logic        predict_taken;
   } req_type;

   typedef struct packed {
      logic [5:0]         op_code;
      logic signed [31:0] immediate;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [4:0]         dest_reg;
      logic [7:0]         history_tag;
      logic [31:0]        carried_value;
      logic [31:0]        next_pc;
      logic               fetch_stall;
   } rsp_type;

endpackage

// ===== hw/rtl/rv32dp_decode.sv =====
module rv32dp_decode (
   input  rv32dp_pkg::req_type req,
   output rv32dp_pkg::rsp_type rsp
);
   import rv32dp_pkg::*;

   logic [31:0] w;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] pc_plus4;
   logic [31:0] pc_target;
   logic [31:0] imm_sel;
   logic [5:0]  code;
   logic        is_branch;
   logic        is_jal;

   assign w     = req.instr_word;
   assign opc   = w[6:0];
   assign f3    = w[14:12];
   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_u = {w[31:12], 12'b0};
   assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

   // one target adder: only JAL and branches use pc+imm
   assign pc_plus4  = req.fetch_pc + 32'd4;
   assign pc_target = req.fetch_pc + ((opc == OPC_JAL) ? imm_j : imm_b);

   always_comb begin
      code    = OP_ILLEGAL;
      imm_sel = 32'd0;
      case (opc)
         OPC_LUI: begin
            code    = OP_LUI;
            imm_sel = imm_u;
         end
         OPC_AUIPC: begin
            code    = OP_AUIPC;
            imm_sel = imm_u;
         end
         OPC_JAL: begin
            code    = OP_JAL;
            imm_sel = imm_j;
         end
         OPC_JALR: begin
            code    = OP_JALR;
            imm_sel = imm_i;
         end
         OPC_BRANCH: begin
            imm_sel = imm_b;
            case (f3)
               3'd0:    code = OP_BEQ;
               3'd1:    code = OP_BNE;
               3'd4:    code = OP_BLT;
               3'd5:    code = OP_BGE;
               3'd6:    code = OP_BLTU;
               3'd7:    code = OP_BGEU;
               default: code = OP_ILLEGAL;
            endcase
         end
         OPC_LOAD: begin
            imm_sel = imm_i;
            case (f3)
               3'd0:    code = OP_LB;
               3'd1:    code = OP_LH;
               3'd2:    code = OP_LW;
               3'd4:    code = OP_LBU;
               3'd5:    code = OP_LHU;
               default: code = OP_ILLEGAL;
            endcase
         end
         OPC_STORE: begin
            imm_sel = imm_s;
            case (f3)
               3'd0:    code = OP_SB;
               3'd1:    code = OP_SH;
               3'd2:    code = OP_SW;
               default: code = OP_ILLEGAL;
            endcase
         end
         OPC_IMM: begin
            imm_sel = imm_i;
            case (f3)
               3'd0:    code = OP_ADDI;
               3'd1:    code = OP_SLLI;
               3'd2:    code = OP_SLTI;
               3'd3:    code = OP_SLTIU;
               3'd4:    code = OP_XORI;
               3'd5: begin
                  if (w[30]) begin
                     code    = OP_SRAI;
                     imm_sel = {27'd0, w[24:20]};
                  end else begin
                     code = OP_SRLI;
                  end
               end
               3'd6:    code = OP_ORI;
               default: code = OP_ANDI;
            endcase
         end
         OPC_REG: begin
            case (f3)
               3'd0:    code = w[30] ? OP_SUB : OP_ADD;
               3'd1:    code = OP_SLL;
               3'd2:    code = OP_SLT;
               3'd3:    code = OP_SLTU;
               3'd4:    code = OP_XOR;
               3'd5:    code = w[30] ? OP_SRA : OP_SRL;
               3'd6:    code = OP_OR;
               default: code = OP_AND;
            endcase
         end
         default: begin
            code    = OP_ILLEGAL;
            imm_sel = 32'd0;
         end
      endcase
   end

   assign is_branch = (opc == OPC_BRANCH) && (code != OP_ILLEGAL);
   assign is_jal    = (opc == OPC_JAL);

   always_comb begin
      rsp.op_code       = code;
      rsp.immediate     = imm_sel;
      rsp.src1_reg      = w[19:15];
      rsp.src2_reg      = w[24:20];
      rsp.dest_reg      = w[11:7];
      rsp.history_tag   = 8'd0;
      rsp.carried_value = req.fetch_pc;
      rsp.next_pc       = pc_plus4;
      rsp.fetch_stall   = 1'b0;
      if (w == HALT_WORD) begin
         rsp.op_code     = OP_HALT;
         rsp.immediate   = 32'd0;
         rsp.src1_reg    = 5'd0;
         rsp.src2_reg    = 5'd0;
         rsp.dest_reg    = 5'd0;
         rsp.next_pc     = req.fetch_pc;
         rsp.fetch_stall = 1'b1;
      end else if (opc == OPC_JALR) begin
         rsp.next_pc     = req.fetch_pc;
         rsp.fetch_stall = 1'b1;
      end else if (is_jal) begin
         rsp.next_pc = pc_target;
      end else if (is_branch) begin
         rsp.history_tag = {w[8], w[7], w[20], w[15], f3, req.predict_taken};
         if (req.predict_taken) begin
            rsp.next_pc       = pc_target;
            rsp.carried_value = pc_plus4;
         end else begin
            rsp.carried_value = pc_target;
         end
      end
   end

endmodule

// ===== hw/rtl/rv32i_decode_and_predict_fetch.sv =====
// Channel   Ports                          Dir   Payload
// request   req_valid/req_ready/req_data   in    instr_word, fetch_pc, predict_taken
// response  rsp_valid/rsp_ready/rsp_data   out   op_code .. fetch_stall
//
// Input register, then decode and the pc adders, then the response register.
// rsp_valid rises once a transferred request has moved through the input register
// into the response register; one instruction per cycle is sustained while rsp_ready is high.
// Reset (synchronous, active high) clears both valid bits; payload is not reset.
// On a response stall the pipeline holds; req_ready stays high while the
// input register is empty or can move into the response register.
module rv32i_decode_and_predict_fetch (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rv32dp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rv32dp_pkg::rsp_type rsp_data
);
   import rv32dp_pkg::*;

   // input stage
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_ff;

   // response stage
   logic    s2_valid_ff;
   logic    s2_valid_in;
   rsp_type s2_ff;
   rsp_type s2_in;

   logic    s1_advance;
   logic    req_xfer;

   rv32dp_decode u_decode (
      .req (s1_ff),
      .rsp (s2_in)
   );

   // stage 1 may move on when the response slot is free or being drained
   assign s1_advance = !s2_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_advance) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= req_data;
      end
      if (s1_advance && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_ff;

`ifndef NO_ASSERTIONS
   // a request transfer always lands in the input stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("request transfer lost");

   // a blocked input stage keeps its instruction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("input stage changed while blocked");

   // stall flag only for JALR and halt
   a_stall_ops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fetch_stall) |->
         (rsp_data.op_code == OP_JALR || rsp_data.op_code == OP_HALT))
      else $error("fetch stall on wrong op");

   // stalled fetch holds the pc
   a_stall_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fetch_stall) |->
         (rsp_data.next_pc == rsp_data.carried_value))
      else $error("stalled fetch moved the pc");

   // history tag only on legal branches
   a_tag_branch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.history_tag != 8'd0) |->
         (rsp_data.op_code >= OP_BEQ && rsp_data.op_code <= OP_BGEU))
      else $error("history tag on non-branch");
`endif

endmodule
